@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define SWARQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Condition that must never hold outside reset
`define SWARQ_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/swarq_pkg.sv @@
// Package: codes, constants and word types of the stop-and-wait ARQ sender
`default_nettype none

package swarq_pkg;

  // Fixed field widths
  localparam int WORD_BITS  = 32;
  localparam int KIND_BITS  = 3;
  localparam int STATE_BITS = 2;
  localparam int QUEUED_BITS = 5;
  localparam int CNT_BITS   = 32;
  localparam int TIMER_BITS = 16;

  // Defaults
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam logic [TIMER_BITS-1:0] TIMEOUT_RESET = 16'd1000;

  // Event kinds
  localparam logic [KIND_BITS-1:0] KIND_NEW    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_TXDONE = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_ACK    = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_NACK   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_TICK   = 3'd4;

  // Sender state codes as seen on the result word
  localparam logic [STATE_BITS-1:0] ST_IDLE    = 2'd0;
  localparam logic [STATE_BITS-1:0] ST_SENDING = 2'd1;
  localparam logic [STATE_BITS-1:0] ST_WAIT    = 2'd2;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [WORD_BITS-1:0] packet_word;
  } in_word_t;

  typedef struct packed {
    logic                   send_valid;
    logic [WORD_BITS-1:0]   send_word;
    logic [STATE_BITS-1:0]  sender_state;
    logic                   dropped;
    logic [QUEUED_BITS-1:0] queued;
    logic [CNT_BITS-1:0]    acked_count;
    logic [CNT_BITS-1:0]    transmitted_count;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/swarq_qmem.sv @@
// Wait queue memory with a prefetched head word and write forwarding
`default_nettype none

module swarq_qmem #(
  parameter int DEPTH = swarq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [AW-1:0]                   waddr,
  input  wire logic [swarq_pkg::WORD_BITS-1:0] wdata,
  input  wire logic [AW-1:0]                   raddr,
  output logic      [swarq_pkg::WORD_BITS-1:0] rdata
);

  logic [swarq_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic [swarq_pkg::WORD_BITS-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read; a write to the entry being read is passed straight on
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/swarq_core.sv @@
// Sender state, queue pointers, timer and counters; result word of each event
`default_nettype none

module swarq_core #(
  parameter int QUEUE_DEPTH = swarq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire swarq_pkg::in_word_t              item,
  input  wire logic [swarq_pkg::TIMER_BITS-1:0] timeout,
  output swarq_pkg::out_word_t                  result
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);

  typedef enum logic [swarq_pkg::STATE_BITS-1:0] {
    PH_IDLE    = swarq_pkg::ST_IDLE,
    PH_SENDING = swarq_pkg::ST_SENDING,
    PH_WAIT    = swarq_pkg::ST_WAIT
  } phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [swarq_pkg::WORD_BITS-1:0]   held_r, held_nxt;
  logic                              held_valid_r, held_valid_nxt;
  logic [AW-1:0]                     head_r, head_nxt;
  logic [AW-1:0]                     tail_r, tail_nxt;
  logic [FW-1:0]                     fill_r, fill_nxt;
  logic [swarq_pkg::TIMER_BITS-1:0]  timer_r, timer_nxt;
  logic                              armed_r, armed_nxt;
  logic [swarq_pkg::CNT_BITS-1:0]    ack_r, ack_nxt;
  logic [swarq_pkg::CNT_BITS-1:0]    tx_r, tx_nxt;

  logic                              send;
  logic                              drop;
  logic                              push;
  logic [swarq_pkg::WORD_BITS-1:0]   head_word;

  // queue storage; read address follows the next head so the word is ready
  swarq_qmem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_qmem (
    .clk   (clk),
    .we    (push),
    .waddr (tail_r),
    .wdata (item.packet_word),
    .raddr (head_nxt),
    .rdata (head_word)
  );

  // event decode and next state
  always_comb begin
    phase_nxt      = phase_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    timer_nxt      = timer_r;
    armed_nxt      = armed_r;
    ack_nxt        = ack_r;
    tx_nxt         = tx_r;
    send           = 1'b0;
    drop           = 1'b0;
    push           = 1'b0;
    if (step) begin
      case (item.kind)
        swarq_pkg::KIND_NEW: begin
          if ((phase_r == PH_IDLE) && !held_valid_r) begin
            held_nxt       = item.packet_word;
            held_valid_nxt = 1'b1;
            send           = 1'b1;
          end else if (fill_r < FILL_MAX) begin
            push     = 1'b1;
            tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
            fill_nxt = fill_r + 1'b1;
          end else begin
            drop = 1'b1;
          end
        end
        swarq_pkg::KIND_TXDONE: begin
          if (phase_r == PH_SENDING) begin
            phase_nxt = PH_WAIT;
            timer_nxt = timeout;
            armed_nxt = 1'b1;
            tx_nxt    = tx_r + 1'b1;
          end
        end
        swarq_pkg::KIND_ACK: begin
          if (held_valid_r) begin
            armed_nxt = 1'b0;
            ack_nxt   = ack_r + 1'b1;
            if (fill_r == '0) begin
              held_valid_nxt = 1'b0;
              phase_nxt      = PH_IDLE;
            end else begin
              held_nxt = head_word;
              head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
              fill_nxt = fill_r - 1'b1;
              send     = 1'b1;
            end
          end
        end
        swarq_pkg::KIND_NACK: begin
          send = held_valid_r;
        end
        swarq_pkg::KIND_TICK: begin
          if (armed_r && held_valid_r) begin
            if (timer_r <= 16'd1) begin
              timer_nxt = '0;
              send      = 1'b1;
            end else begin
              timer_nxt = timer_r - 1'b1;
            end
          end
        end
        default: begin
          // undefined kinds change nothing
        end
      endcase
      // a copy goes out: back to sending, timer off
      if (send) begin
        phase_nxt = PH_SENDING;
        armed_nxt = 1'b0;
      end
    end
  end

  // result word of the event
  always_comb begin
    result.send_valid        = send;
    result.send_word         = send ? held_nxt : '0;
    result.sender_state      = phase_nxt;
    result.dropped           = drop;
    result.queued            = swarq_pkg::QUEUED_BITS'(fill_nxt);
    result.acked_count       = ack_nxt;
    result.transmitted_count = tx_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      timer_r      <= '0;
      armed_r      <= 1'b0;
      ack_r        <= '0;
      tx_r         <= '0;
    end else begin
      phase_r      <= phase_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fill_r       <= fill_nxt;
      timer_r      <= timer_nxt;
      armed_r      <= armed_nxt;
      ack_r        <= ack_nxt;
      tx_r         <= tx_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stop_and_wait_arq_sender.sv @@
// Stop-and-wait ARQ sender: one result word per event word.
// The result word is registered when the event word is taken.
// Throughput: one event word per cycle while out_stall is low; the queue memory
// is read ahead of the head, so an ACK pops the next packet without a bubble.
// Reset (synchronous, active low) empties the queue and clears state and counts;
// the queue memory itself needs no clearing pass.
`default_nettype none

module stop_and_wait_arq_sender #(
  parameter int QUEUE_DEPTH = swarq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // event words
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire swarq_pkg::in_word_t              in_data,
  // result words
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output swarq_pkg::out_word_t                  out_data,
  // timeout register
  input  wire logic                             cfg_we,
  input  wire logic [swarq_pkg::TIMER_BITS-1:0] cfg_wdata
);

  `include "assert_macros.svh"

  logic [swarq_pkg::TIMER_BITS-1:0] timeout_r;
  logic                             out_valid_r, out_valid_nxt;
  swarq_pkg::out_word_t             out_data_r;
  swarq_pkg::out_word_t             result;
  logic                             step;

  // take a word unless the held result is blocked
  assign in_stall = out_valid_r && out_stall;
  assign step     = in_valid && !in_stall;

  swarq_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .item    (in_data),
    .timeout (timeout_r),
    .result  (result)
  );

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= swarq_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // output register
  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a sent copy always leaves the sender in the sending state
  `SWARQ_ASSERT_IMP(a_send_state, clk, rst_n, out_valid_r && out_data_r.send_valid,
    out_data_r.sender_state == swarq_pkg::ST_SENDING)
  // idle only with an empty queue
  `SWARQ_ASSERT_IMP(a_idle_empty, clk, rst_n,
    out_valid_r && (out_data_r.sender_state == swarq_pkg::ST_IDLE), out_data_r.queued == '0)
  // no word shown unless a copy is sent
  `SWARQ_ASSERT_IMP(a_word_zero, clk, rst_n, out_valid_r && !out_data_r.send_valid,
    out_data_r.send_word == '0)
  // a drop never comes with a send
  `SWARQ_ASSERT_NEVER(a_drop_send, clk, rst_n,
    out_valid_r && out_data_r.dropped && out_data_r.send_valid)

endmodule

`default_nettype wire

@@ tb/stop_and_wait_arq_sender_tb.sv @@
// Testbench: random and directed event words against a scoreboard model of the ARQ sender
`default_nettype none

module stop_and_wait_arq_sender_tb;
  import swarq_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP   = 40;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;
  // timeout per phase: zero, both extremes and a spread of short ones
  localparam logic [TIMER_BITS-1:0] TIMEOUTS [PHASES] =
    '{16'd0, 16'd1, 16'd65535, 16'd3, 16'd2, 16'd1, 16'd5, 16'd4};
  // most new packets per exchange; above two the backlog grows until words drop
  localparam int LOADS [PHASES] = '{1, 3, 2, 4, 1, 2, 3, 1};

  // Scoreboard: mirrors the sender and queues the result word each event should give
  class arq_scoreboard;
    logic [TIMER_BITS-1:0] timeout_ticks;
    logic [STATE_BITS-1:0] link_phase;
    logic [WORD_BITS-1:0]  held_word;
    bit                    holding;
    logic [WORD_BITS-1:0]  backlog [DEPTH];
    int                    head;
    int                    fill;
    logic [TIMER_BITS-1:0] timer;
    bit                    armed;
    logic [CNT_BITS-1:0]   ack_total;
    logic [CNT_BITS-1:0]   tx_total;
    out_word_t             expected_q [$];
    int                    errors;

    function new();
      timeout_ticks = TIMEOUT_RESET;
      link_phase    = ST_IDLE;
      held_word     = '0;
      holding       = 0;
      head          = 0;
      fill          = 0;
      timer         = '0;
      armed         = 0;
      ack_total     = '0;
      tx_total      = '0;
      errors        = 0;
    endfunction

    function void set_timeout(logic [TIMER_BITS-1:0] v);
      timeout_ticks = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // put the held packet on the link
    function void launch(inout out_word_t e);
      e.send_valid = 1'b1;
      e.send_word  = held_word;
      link_phase   = ST_SENDING;
      armed        = 0;
    endfunction

    function void note_event(in_word_t ev);
      out_word_t e;
      e = '0;
      case (ev.kind)
        KIND_NEW: begin
          if (link_phase == ST_IDLE && !holding) begin
            held_word = ev.packet_word;
            holding   = 1;
            launch(e);
          end else if (fill < DEPTH) begin
            backlog[(head + fill) % DEPTH] = ev.packet_word;
            fill++;
          end else begin
            e.dropped = 1'b1;
          end
        end
        KIND_TXDONE: begin
          if (link_phase == ST_SENDING) begin
            link_phase = ST_WAIT;
            timer      = timeout_ticks;
            armed      = 1;
            tx_total   = tx_total + 1'b1;
          end
        end
        KIND_ACK: begin
          // accepted while still sending as well as while waiting
          if (holding) begin
            armed     = 0;
            ack_total = ack_total + 1'b1;
            if (fill == 0) begin
              holding    = 0;
              link_phase = ST_IDLE;
            end else begin
              held_word = backlog[head];
              head      = (head + 1) % DEPTH;
              fill--;
              launch(e);
            end
          end
        end
        KIND_NACK: begin
          if (holding) begin
            launch(e);
          end
        end
        KIND_TICK: begin
          // a zero timeout fires on the first tick
          if (armed && holding) begin
            if (timer <= 1) begin
              timer = '0;
              launch(e);
            end else begin
              timer = timer - 1'b1;
            end
          end
        end
        default: ;
      endcase
      e.sender_state      = link_phase;
      e.queued            = QUEUED_BITS'(fill);
      e.acked_count       = ack_total;
      e.transmitted_count = tx_total;
      expected_q.push_back(e);
    endfunction

    task report(string what, logic [WORD_BITS-1:0] got, logic [WORD_BITS-1:0] want);
      errors++;
      if (errors <= PRINT_CAP)
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result word", got.send_word, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.send_valid !== want.send_valid)
        report("send_valid", WORD_BITS'(got.send_valid), WORD_BITS'(want.send_valid));
      if (got.send_word !== want.send_word)
        report("send_word", got.send_word, want.send_word);
      if (got.sender_state !== want.sender_state)
        report("sender_state", WORD_BITS'(got.sender_state), WORD_BITS'(want.sender_state));
      if (got.dropped !== want.dropped)
        report("dropped", WORD_BITS'(got.dropped), WORD_BITS'(want.dropped));
      if (got.queued !== want.queued)
        report("queued", WORD_BITS'(got.queued), WORD_BITS'(want.queued));
      if (got.acked_count !== want.acked_count)
        report("acked_count", got.acked_count, want.acked_count);
      if (got.transmitted_count !== want.transmitted_count)
        report("transmitted_count", got.transmitted_count, want.transmitted_count);
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [TIMER_BITS-1:0] cfg_wdata = '0;

  arq_scoreboard         sb = new();
  int                    cycles = 0;
  int                    burst_left = 0;
  int                    sent = 0;
  logic [TIMER_BITS-1:0] tmo_now = TIMEOUT_RESET;

  stop_and_wait_arq_sender dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL stop_and_wait_arq_sender");
      $finish;
    end
  end

  // both handshakes seen at the same edge: the event is noted before any result is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_event(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // result side back-pressure: free runs, light and heavy random stalls, a fixed pattern
  int stall_mode = 0;
  int stall_left = 0;
  int stall_step = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_step++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_step % 5) < 2);
    endcase
  end

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one event word and hold it until taken; in_valid drops between bursts
  task automatic push(input logic [KIND_BITS-1:0] k, input logic [WORD_BITS-1:0] w);
    in_word_t ev;
    ev.kind        = k;
    ev.packet_word = w;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    sent++;
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int goal;
    int r;
    int ticks;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ignored events, undefined kinds, queueing, nack, ack while sending
    push(KIND_ACK, 32'h0);
    push(KIND_NACK, 32'h0);
    push(KIND_TICK, 32'h0);
    push(KIND_TXDONE, 32'h0);
    push(3'd5, 32'h0);
    push(3'd6, 32'hFFFF_FFFF);
    push(3'd7, 32'h5A5A_A5A5);
    push(KIND_NEW, 32'hFFFF_FFFF);
    push(KIND_NEW, 32'h0);
    push(KIND_TXDONE, 32'h0);
    push(KIND_TXDONE, 32'h0);
    push(KIND_TICK, 32'h0);
    push(KIND_NACK, 32'h0);
    push(KIND_TICK, 32'h0);
    push(KIND_TXDONE, 32'h0);
    push(KIND_ACK, 32'h0);
    push(KIND_ACK, 32'h0);
    push(KIND_NEW, 32'h1234_5678);
    push(KIND_TXDONE, 32'h0);
    push(KIND_ACK, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      // timeout written only once the block has gone quiet
      in_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clk);
      while (sb.pending() != 0) @(posedge clk);
      repeat (3) @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= TIMEOUTS[p];
      sb.set_timeout(TIMEOUTS[p]);
      tmo_now = TIMEOUTS[p];
      @(posedge clk);
      cfg_we <= 1'b0;

      // mostly whole exchanges with random content, some noise words
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        if ($urandom_range(0, 99) < 15) begin
          push(KIND_BITS'($urandom_range(0, 7)), $urandom);
        end else begin
          repeat ($urandom_range(0, LOADS[p])) push(KIND_NEW, pick_word());
          r = $urandom_range(0, 9);
          if (r == 0) begin
            push(KIND_ACK, $urandom);
          end else begin
            push(KIND_TXDONE, $urandom);
            if (r < 5) begin
              push(KIND_ACK, $urandom);
            end else if (r < 7) begin
              push(KIND_NACK, $urandom);
              push(KIND_TXDONE, $urandom);
              push(KIND_ACK, $urandom);
            end else begin
              ticks = (tmo_now > 6) ? $urandom_range(0, 8) : $urandom_range(0, tmo_now + 2);
              repeat (ticks) push(KIND_TICK, $urandom);
              push(KIND_TXDONE, $urandom);
              push(KIND_ACK, $urandom);
            end
          end
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS stop_and_wait_arq_sender");
    else
      $display("FAIL stop_and_wait_arq_sender");
    $finish;
  end

endmodule

`default_nettype wire
